### src/rte_pkg.sv
`timescale 1ns / 1ps

package rte_pkg;

    // Fraction digits kept, at most nine (nanosecond resolution)
    localparam int unsigned MAX_FRAC_DIGITS = 9;

    localparam logic [5:0] POS_MAX = 6'd63;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Multiplier constants of the shared unit
    localparam logic signed [17:0] K_DIV100     = 18'sd5243;   // x/100 = (x*5243) >> 19
    localparam logic signed [17:0] K_YEAR_DAYS  = 18'sd365;
    localparam logic signed [17:0] K_DAY_SECS   = 18'sd86400;
    localparam logic signed [17:0] K_HOUR_SECS  = 18'sd3600;
    localparam logic signed [17:0] K_MIN_SECS   = 18'sd60;
    localparam logic signed [17:0] K_ONE        = 18'sd1;
    localparam logic signed [39:0] K_EPOCH_DAYS = 40'sd719468;

    typedef enum logic [2:0] {
        PH_DATETIME  = 3'd0,
        PH_AFTER_SEC = 3'd1,
        PH_FRACTION  = 3'd2,
        PH_ZONE      = 3'd3,
        PH_DONE      = 3'd4
    } rte_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_QY   = 4'd1,
        ST_QA   = 4'd2,
        ST_DAYS = 4'd3,
        ST_SEC  = 4'd4,
        ST_HR   = 4'd5,
        ST_MIN  = 4'd6,
        ST_SS   = 4'd7,
        ST_ZH   = 4'd8,
        ST_ZM   = 4'd9,
        ST_FIN  = 4'd10
    } rte_state_t;

    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] nanos;
        logic        zone_neg;
        logic [6:0]  zone_hour;
        logic [6:0]  zone_minute;
        logic        done;
        logic        err;
    } rte_fields_t;

    typedef struct packed {
        logic        valid;
        logic [38:0] secs;
        logic [29:0] nanos;
    } rte_result_t;

    // Weight of each fraction digit in nanoseconds
    function automatic logic [26:0] digit_scale(input logic [3:0] idx);
        logic [26:0] s;
        begin
            case (idx)
                4'd0:    s = 27'd100000000;
                4'd1:    s = 27'd10000000;
                4'd2:    s = 27'd1000000;
                4'd3:    s = 27'd100000;
                4'd4:    s = 27'd10000;
                4'd5:    s = 27'd1000;
                4'd6:    s = 27'd100;
                4'd7:    s = 27'd10;
                4'd8:    s = 27'd1;
                default: s = 27'd0;
            endcase
            return s;
        end
    endfunction

    // Days in month (1..12)
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] d;
        begin
            case (m)
                4'd2:                      d = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7,
                4'd8, 4'd10, 4'd12:        d = 5'd31;
                default:                   d = 5'd0;
            endcase
            return d;
        end
    endfunction

    // Days from March 1 to the first of the month, year starting in March
    function automatic logic [8:0] march_offset(input logic [3:0] m);
        logic [8:0] d;
        begin
            case (m)
                4'd3:    d = 9'd0;
                4'd4:    d = 9'd31;
                4'd5:    d = 9'd61;
                4'd6:    d = 9'd92;
                4'd7:    d = 9'd122;
                4'd8:    d = 9'd153;
                4'd9:    d = 9'd184;
                4'd10:   d = 9'd214;
                4'd11:   d = 9'd245;
                4'd12:   d = 9'd275;
                4'd1:    d = 9'd306;
                4'd2:    d = 9'd337;
                default: d = 9'd0;
            endcase
            return d;
        end
    endfunction

endpackage

### src/rte_char_parser.sv
`timescale 1ns / 1ps

module rte_char_parser
    import rte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  text_char,
    input  logic        clear,
    output rte_fields_t fields
);

    logic [5:0]  pos_reg, pos_next;
    rte_phase_t  phase_reg, phase_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [29:0] nanos_reg, nanos_next;
    logic [3:0]  frac_cnt_reg, frac_cnt_next;
    logic [2:0]  zone_cnt_reg, zone_cnt_next;
    logic        zone_neg_reg, zone_neg_next;
    logic [6:0]  zone_hour_reg, zone_hour_next;
    logic [6:0]  zone_min_reg, zone_min_next;
    logic        err_reg, err_next;

    logic        is_dig;
    logic [3:0]  dig;
    logic [30:0] frac_add;

    function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
        return 7'({acc, 3'b000} + {acc, 1'b0} + {3'd0, d});
    endfunction

    function automatic logic [13:0] push14(input logic [13:0] acc, input logic [3:0] d);
        return 14'({acc, 3'b000} + {acc, 1'b0} + {10'd0, d});
    endfunction

    assign is_dig   = (text_char >= CH_ZERO) && (text_char <= CH_NINE);
    assign dig      = 4'(text_char - CH_ZERO);
    assign frac_add = dig * digit_scale(frac_cnt_reg);

    always_comb
    begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        nanos_next     = nanos_reg;
        frac_cnt_next  = frac_cnt_reg;
        zone_cnt_next  = zone_cnt_reg;
        zone_neg_next  = zone_neg_reg;
        zone_hour_next = zone_hour_reg;
        zone_min_next  = zone_min_reg;
        err_next       = err_reg;

        if (clear)
        begin
            pos_next       = '0;
            phase_next     = PH_DATETIME;
            year_next      = '0;
            month_next     = '0;
            day_next       = '0;
            hour_next      = '0;
            minute_next    = '0;
            second_next    = '0;
            nanos_next     = '0;
            frac_cnt_next  = '0;
            zone_cnt_next  = '0;
            zone_neg_next  = 1'b0;
            zone_hour_next = '0;
            zone_min_next  = '0;
            err_next       = 1'b0;
        end
        else if (accept)
        begin
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 6'd1;
            end
            if (!err_reg)
            begin
                unique case (phase_reg)
                    PH_DATETIME:
                    begin
                        if (pos_reg == 6'd4 || pos_reg == 6'd7)
                        begin
                            err_next = (text_char != CH_DASH);
                        end
                        else if (pos_reg == 6'd10)
                        begin
                            err_next = (text_char != CH_T);
                        end
                        else if (pos_reg == 6'd13 || pos_reg == 6'd16)
                        begin
                            err_next = (text_char != CH_COLON);
                        end
                        else if (!is_dig)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            if (pos_reg < 6'd4)
                                year_next = push14(year_reg, dig);
                            else if (pos_reg < 6'd7)
                                month_next = push7(month_reg, dig);
                            else if (pos_reg < 6'd10)
                                day_next = push7(day_reg, dig);
                            else if (pos_reg < 6'd13)
                                hour_next = push7(hour_reg, dig);
                            else if (pos_reg < 6'd16)
                                minute_next = push7(minute_reg, dig);
                            else
                                second_next = push7(second_reg, dig);
                            if (pos_reg == 6'd18)
                                phase_next = PH_AFTER_SEC;
                        end
                    end
                    PH_AFTER_SEC, PH_FRACTION:
                    begin
                        if (phase_reg == PH_AFTER_SEC && text_char == CH_DOT)
                        begin
                            frac_cnt_next = '0;
                            phase_next    = PH_FRACTION;
                        end
                        else if (phase_reg == PH_FRACTION && is_dig)
                        begin
                            if (32'(frac_cnt_reg) >= MAX_FRAC_DIGITS)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                nanos_next    = 30'(nanos_reg + frac_add);
                                frac_cnt_next = frac_cnt_reg + 4'd1;
                            end
                        end
                        else if (phase_reg == PH_FRACTION && frac_cnt_reg == 4'd0)
                        begin
                            // dot with no digit after it
                            err_next = 1'b1;
                        end
                        else if (text_char == CH_Z)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (text_char == CH_PLUS || text_char == CH_DASH)
                        begin
                            zone_neg_next = (text_char == CH_DASH);
                            zone_cnt_next = '0;
                            phase_next    = PH_ZONE;
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    PH_ZONE:
                    begin
                        if (zone_cnt_reg == 3'd2)
                            err_next = (text_char != CH_COLON);
                        else if (!is_dig)
                            err_next = 1'b1;
                        else if (zone_cnt_reg < 3'd2)
                            zone_hour_next = push7(zone_hour_reg, dig);
                        else
                            zone_min_next = push7(zone_min_reg, dig);
                        zone_cnt_next = zone_cnt_reg + 3'd1;
                        if (zone_cnt_reg >= 3'd4)
                            phase_next = PH_DONE;
                    end
                    default:
                    begin
                        // anything after the zone
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_DATETIME;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            nanos_reg     <= '0;
            frac_cnt_reg  <= '0;
            zone_cnt_reg  <= '0;
            zone_neg_reg  <= 1'b0;
            zone_hour_reg <= '0;
            zone_min_reg  <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            second_reg    <= second_next;
            nanos_reg     <= nanos_next;
            frac_cnt_reg  <= frac_cnt_next;
            zone_cnt_reg  <= zone_cnt_next;
            zone_neg_reg  <= zone_neg_next;
            zone_hour_reg <= zone_hour_next;
            zone_min_reg  <= zone_min_next;
            err_reg       <= err_next;
        end
    end

    assign fields.year        = year_reg;
    assign fields.month       = month_reg;
    assign fields.day         = day_reg;
    assign fields.hour        = hour_reg;
    assign fields.minute      = minute_reg;
    assign fields.second      = second_reg;
    assign fields.nanos       = nanos_reg;
    assign fields.zone_neg    = zone_neg_reg;
    assign fields.zone_hour   = zone_hour_reg;
    assign fields.zone_minute = zone_min_reg;
    assign fields.done        = (phase_reg == PH_DONE);
    assign fields.err         = err_reg;

endmodule

### src/rte_calc.sv
`timescale 1ns / 1ps

module rte_calc
    import rte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        take,
    input  rte_fields_t fields,
    output logic        idle,
    output logic        done,
    output rte_result_t result
);

    rte_state_t         state_reg, state_next;
    logic signed [39:0] acc_reg, acc_next;
    logic [7:0]         qy_reg;

    // shared multiply-add unit
    logic signed [23:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [39:0] add_c;
    logic signed [41:0] prod;
    logic               acc_we;

    logic [13:0]        yadj;
    logic [7:0]         qa;
    logic signed [39:0] day_base;
    logic               y_div4, y_div100, leap;
    logic [4:0]         dim;
    logic               ok;

    assign yadj = fields.year - {13'd0, (fields.month <= 7'd2)};
    assign qa   = acc_reg[26:19];

    // yadj/4 - yadj/100 + yadj/400 + day of year - epoch offset
    assign day_base = $signed({28'd0, yadj[13:2]}) - $signed({32'd0, qa})
                    + $signed({34'd0, qa[7:2]})
                    + $signed({31'd0, march_offset(fields.month[3:0])})
                    + $signed({33'd0, fields.day}) - 40'sd1 - K_EPOCH_DAYS;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_QY;
            ST_QY:   state_next = ST_QA;
            ST_QA:   state_next = ST_DAYS;
            ST_DAYS: state_next = ST_SEC;
            ST_SEC:  state_next = ST_HR;
            ST_HR:   state_next = ST_MIN;
            ST_MIN:  state_next = ST_SS;
            ST_SS:   state_next = ST_ZH;
            ST_ZH:   state_next = ST_ZM;
            ST_ZM:   state_next = ST_FIN;
            ST_FIN:  if (take) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        add_c  = '0;
        acc_we = 1'b1;
        unique case (state_reg)
            ST_QY:
            begin
                mul_a = $signed({10'd0, fields.year});
                mul_b = K_DIV100;
            end
            ST_QA:
            begin
                mul_a = $signed({10'd0, yadj});
                mul_b = K_DIV100;
            end
            ST_DAYS:
            begin
                mul_a = $signed({10'd0, yadj});
                mul_b = K_YEAR_DAYS;
                add_c = day_base;
            end
            ST_SEC:
            begin
                mul_a = acc_reg[23:0];
                mul_b = K_DAY_SECS;
            end
            ST_HR:
            begin
                mul_a = $signed({17'd0, fields.hour});
                mul_b = K_HOUR_SECS;
                add_c = acc_reg;
            end
            ST_MIN:
            begin
                mul_a = $signed({17'd0, fields.minute});
                mul_b = K_MIN_SECS;
                add_c = acc_reg;
            end
            ST_SS:
            begin
                mul_a = $signed({17'd0, fields.second});
                mul_b = K_ONE;
                add_c = acc_reg;
            end
            ST_ZH:
            begin
                mul_a = $signed({17'd0, fields.zone_hour});
                mul_b = fields.zone_neg ? K_HOUR_SECS : -K_HOUR_SECS;
                add_c = acc_reg;
            end
            ST_ZM:
            begin
                mul_a = $signed({17'd0, fields.zone_minute});
                mul_b = fields.zone_neg ? K_MIN_SECS : -K_MIN_SECS;
                add_c = acc_reg;
            end
            default:
            begin
                acc_we = 1'b0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign acc_next = $signed(prod[39:0]) + add_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_reg <= acc_next;
        end
        if (state_reg == ST_QA)
        begin
            qy_reg <= acc_reg[26:19];
        end
    end

    // calendar and zone checks, valid in ST_FIN
    assign y_div4   = (fields.year[1:0] == 2'd0);
    assign y_div100 = ({1'b0, qy_reg, 6'd0} + {2'b0, qy_reg, 5'd0} + {5'd0, qy_reg, 2'd0})
                      == {1'b0, fields.year};
    assign leap     = y_div4 && (!y_div100 || (qy_reg[1:0] == 2'd0));
    assign dim      = month_len(fields.month[3:0], leap);

    assign ok = fields.done && !fields.err
             && (fields.year != 14'd0) && (fields.year <= 14'd9999)
             && (fields.month != 7'd0) && (fields.month <= 7'd12)
             && (fields.day != 7'd0) && (fields.day <= {2'd0, dim})
             && (fields.hour <= 7'd23) && (fields.minute <= 7'd59)
             && (fields.second <= 7'd59)
             && (fields.zone_hour <= 7'd23) && (fields.zone_minute <= 7'd59)
             && !(fields.zone_neg && fields.zone_hour == 7'd0 && fields.zone_minute == 7'd0);

    assign idle         = (state_reg == ST_IDLE);
    assign done         = (state_reg == ST_FIN);
    assign result.valid = ok;
    assign result.secs  = ok ? acc_reg[38:0] : 39'd0;
    assign result.nanos = ok ? fields.nanos : 30'd0;

endmodule

### src/rfc3339_timestamp_to_epoch_core.sv
// RFC 3339 timestamp to epoch converter. Text enters one ASCII character per
// request on the s_axis side, tlast on the final character; one result per
// text leaves on m_axis: tuser[0] says whether the text was a valid timestamp
// (YYYY-MM-DDTHH:MM:SS, optional 1..9 digit fraction, then Z or +HH:MM/-HH:MM,
// real Gregorian date in years 1..9999, -00:00 refused), tdata carries UTC
// seconds since 1970 (signed) and nanoseconds; an invalid text gives zeros.
// Every character is accepted while the sequencer is idle. After the last one the
// calendar math runs on a single shared multiply-add unit stepped by a small
// sequencer: nine unit steps, then a final state that hands the result over,
// and s_axis_tready stays low from tlast until that hand-over. If an earlier
// result still sits untaken in the output register, the hand-over waits until
// m_axis drains it, and s_axis_tready stays low that much longer. The result
// sits in an output register, and the next text is accepted while it waits
// to be taken.
`timescale 1ns / 1ps

module rfc3339_timestamp_to_epoch_core
    import rte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_char
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [38:0] utc_seconds, [68:39] nanoseconds, [71:69] 0
    output logic        m_axis_tuser    // [0] valid_res
);

    rte_fields_t fields;
    rte_result_t result;
    logic        in_accept;
    logic        calc_idle;
    logic        calc_done;
    logic        res_take;

    logic        out_valid_reg, out_valid_next;
    logic [38:0] out_secs_reg;
    logic [29:0] out_nanos_reg;
    logic        out_ok_reg;

    // characters flow only while the sequencer is idle
    assign s_axis_tready = calc_idle;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // result moves to the output register once it is free or being drained
    assign res_take = calc_done && (!out_valid_reg || m_axis_tready);

    rte_char_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .text_char (s_axis_tdata),
        .clear     (res_take),
        .fields    (fields)
    );

    rte_calc u_calc (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_accept && s_axis_tlast),
        .take   (res_take),
        .fields (fields),
        .idle   (calc_idle),
        .done   (calc_done),
        .result (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_ok_reg    <= result.valid;
            out_secs_reg  <= result.secs;
            out_nanos_reg <= result.nanos;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_nanos_reg, out_secs_reg};
    assign m_axis_tuser  = out_ok_reg;

endmodule

### src/rte_checker.sv
`timescale 1ns / 1ps

module rte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // an invalid text reports all zeros
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 72'd0)
        else $error("invalid result with nonzero data");

    // nanoseconds stay below one second
    a_nanos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[68:39] < 30'd1000000000)
        else $error("nanoseconds out of range");

    // the final character starts the calendar pass, input stalls
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready right after final character");

endmodule

bind rfc3339_timestamp_to_epoch_core rte_checker u_rte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
